[hw/rtl/can_bit_timing_calculator_assert.svh]
// assertion macros for the bit timing calculator
`ifndef CAN_BIT_TIMING_CALCULATOR_ASSERT_SVH
`define CAN_BIT_TIMING_CALCULATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define CBT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbt assertion failed");
`define CBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbt assertion failed");
`else
`define CBT_ASSERT_NOW(lbl, ante, cons)
`define CBT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/cbt_pkg.sv]
`timescale 1ns / 1ps

package cbt_pkg;

    localparam int CBT_MAX_PRESCALER = 64;
    localparam int CBT_BRP_W         = $clog2(CBT_MAX_PRESCALER + 1);

    localparam logic [19:0] CBT_BITRATE_LIMIT = 20'd1000000;
    localparam logic [4:0]  CBT_QUANTA_MIN    = 5'd8;
    localparam logic [7:0]  CBT_SJW_LIMIT     = 8'd4;
    localparam logic [25:0] CBT_OSC_RESET     = 26'd16000000;
    localparam logic [0:0]  CBT_REG_OSC       = 1'b0;

    typedef struct packed {
        logic [19:0] bitrate_hz;
        logic [7:0]  prop_hint_tq;
        logic [7:0]  sync_jump_tq;
    } t_cbt_in;

    typedef struct packed {
        logic                 status;
        logic [CBT_BRP_W-1:0] prescaler;
        logic [2:0]           sync_jump_len;
        logic [3:0]           prop_len;
        logic [3:0]           phase1_len;
        logic [3:0]           phase2_len;
    } t_cbt_out;

    typedef struct packed {
        logic                 done;
        logic                 reject;
        logic [CBT_BRP_W-1:0] brp;
        logic [4:0]           quanta;
    } t_search_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_DONE
    } t_search_state;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SEARCH,
        T_FINISH
    } t_top_state;

endpackage

[hw/rtl/cbt_search.sv]
`timescale 1ns / 1ps

module cbt_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [24:0]          i_half_osc,
    input  logic [19:0]          i_rate,
    output cbt_pkg::t_search_res o_res
);
    import cbt_pkg::*;

    t_search_state        r_state, n_state;
    logic [CBT_BRP_W-1:0] r_brp, n_brp;
    logic [25:0]          r_div, n_div;
    logic [30:0]          r_lim, n_lim;
    logic [24:0]          r_r26, n_r26;
    logic [24:0]          r_rem, n_rem;
    logic [24:0]          r_half, n_half;
    logic [4:0]           r_q, n_q;
    logic [2:0]           r_bit, n_bit;
    logic                 r_reject, n_reject;

    logic [30:0] w_a, w_b;
    logic [31:0] w_diff;
    logic        w_lt;
    logic [24:0] w_rate26;
    logic [30:0] w_div_sh;

    // shared subtract and compare unit
    assign w_div_sh = {5'd0, r_div} << r_bit;
    assign w_a      = (r_state == S_DIV) ? {6'd0, r_rem} : {6'd0, r_half};
    assign w_b      = (r_state == S_DIV) ? w_div_sh : r_lim;
    assign w_diff   = {1'b0, w_a} - {1'b0, w_b};
    assign w_lt     = w_diff[31];

    assign w_rate26 = {1'b0, i_rate, 4'd0} + {2'b0, i_rate, 3'd0} + {4'd0, i_rate, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_brp    <= n_brp;
        r_div    <= n_div;
        r_lim    <= n_lim;
        r_r26    <= n_r26;
        r_rem    <= n_rem;
        r_half   <= n_half;
        r_q      <= n_q;
        r_bit    <= n_bit;
        r_reject <= n_reject;
    end

    always_comb begin
        n_state  = r_state;
        n_brp    = r_brp;
        n_div    = r_div;
        n_lim    = r_lim;
        n_r26    = r_r26;
        n_rem    = r_rem;
        n_half   = r_half;
        n_q      = r_q;
        n_bit    = r_bit;
        n_reject = r_reject;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_brp    = CBT_BRP_W'(1);
                    n_div    = {6'd0, i_rate};
                    n_lim    = {6'd0, w_rate26};
                    n_r26    = w_rate26;
                    n_half   = i_half_osc;
                    n_reject = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_lt) begin
                    n_rem   = r_half;
                    n_q     = '0;
                    n_bit   = 3'd4;
                    n_state = S_DIV;
                end else if (r_brp == CBT_BRP_W'(CBT_MAX_PRESCALER)) begin
                    n_reject = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_brp = r_brp + CBT_BRP_W'(1);
                    n_div = r_div + {6'd0, i_rate};
                    n_lim = r_lim + {6'd0, r_r26};
                end
            end
            S_DIV: begin
                if (!w_lt) begin
                    n_rem        = w_diff[24:0];
                    n_q[r_bit]   = 1'b1;
                end
                if (r_bit == 3'd0) begin
                    n_state = S_DONE;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.done   = (r_state == S_DONE);
    assign o_res.reject = r_reject;
    assign o_res.brp    = r_brp;
    assign o_res.quanta = r_q;

endmodule

[hw/rtl/can_bit_timing_calculator.sv]
`timescale 1ns / 1ps
// channel | direction | handshake                 | word
// request | in        | i_in_valid / o_in_ready   | i_in_word  (t_cbt_in)
// result  | out       | o_out_valid / i_out_ready | o_out_word (t_cbt_out)
// config  | apb       | psel penable pwrite pready| pwdata / prdata (oscillator_hz)
// a request rejected on its fields goes straight to the finish step; otherwise the scan
// tries one prescaler after another and, if one fits, finds the 5-bit quotient bit by bit,
// then the result is finished and registered; scan and quotient use the one shared subtractor
// the finish step waits while an unread result holds the output register
// o_in_ready is high only when no request is in work
// synchronous active-low reset restores the oscillator register to 16 MHz

module can_bit_timing_calculator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cbt_pkg::t_cbt_in  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cbt_pkg::t_cbt_out o_out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import cbt_pkg::*;

    t_top_state           r_state, n_state;
    logic [25:0]          r_osc;
    logic [19:0]          r_rate, n_rate;
    logic [7:0]           r_hint, n_hint;
    logic [7:0]           r_sjw, n_sjw;
    logic                 r_rej, n_rej;
    logic [CBT_BRP_W-1:0] r_brp, n_brp;
    logic [4:0]           r_q, n_q;
    logic                 r_out_valid, n_out_valid;
    t_cbt_out             r_out, n_out;

    logic        w_in_acc;
    logic        w_bad_req;
    logic        w_start;
    logic [19:0] w_rate;
    t_search_res w_res;

    logic [4:0] w_qs;
    logic [7:0] w_hint1, w_lim3, w_adj;
    logic [3:0] w_prop;
    logic [4:0] w_rest, w_ps1, w_ps2;
    logic [2:0] w_sjw1, w_sjwf;
    t_cbt_out   w_word;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CBT_REG_OSC) ? {6'd0, r_osc} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc <= CBT_OSC_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == CBT_REG_OSC) begin
            r_osc <= pwdata[25:0];
        end
    end

    assign o_in_ready = (r_state == T_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_bad_req  = (i_in_word.bitrate_hz == 20'd0)
                     || (i_in_word.bitrate_hz > CBT_BITRATE_LIMIT)
                     || (i_in_word.sync_jump_tq > CBT_SJW_LIMIT);
    assign w_start    = w_in_acc && !w_bad_req;
    assign w_rate     = o_in_ready ? i_in_word.bitrate_hz : r_rate;

    cbt_search u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_half_osc (r_osc[25:1]),
        .i_rate     (w_rate),
        .o_res      (w_res)
    );

    // segment split
    always_comb begin
        w_qs    = r_q - 5'd1;
        w_hint1 = (r_hint == 8'd0) ? 8'd1 : r_hint;
        w_sjw1  = (r_sjw == 8'd0) ? 3'd1 : r_sjw[2:0];
        w_lim3  = {3'd0, w_qs} - 8'd3;
        w_adj   = (w_hint1 > w_lim3) ? w_lim3 : w_hint1;
        w_prop  = (w_adj > 8'd8) ? 4'd8 : w_adj[3:0];
        w_rest  = w_qs - {1'b0, w_prop};
        w_ps1   = {1'b0, w_rest[4:1]};
        w_ps2   = w_rest - w_ps1;
        w_sjwf  = ({2'd0, w_sjw1} >= w_ps2) ? 3'(w_ps2 - 5'd1) : w_sjw1;
        if (r_rej) begin
            w_word        = '0;
            w_word.status = 1'b1;
        end else begin
            w_word.status        = 1'b0;
            w_word.prescaler     = r_brp;
            w_word.sync_jump_len = w_sjwf;
            w_word.prop_len      = w_prop;
            w_word.phase1_len    = w_ps1[3:0];
            w_word.phase2_len    = w_ps2[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_rate <= n_rate;
        r_hint <= n_hint;
        r_sjw  <= n_sjw;
        r_rej  <= n_rej;
        r_brp  <= n_brp;
        r_q    <= n_q;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_rate      = r_rate;
        n_hint      = r_hint;
        n_sjw       = r_sjw;
        n_rej       = r_rej;
        n_brp       = r_brp;
        n_q         = r_q;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            T_IDLE: begin
                if (w_in_acc) begin
                    n_rate  = i_in_word.bitrate_hz;
                    n_hint  = i_in_word.prop_hint_tq;
                    n_sjw   = i_in_word.sync_jump_tq;
                    n_rej   = w_bad_req;
                    n_state = w_bad_req ? T_FINISH : T_SEARCH;
                end
            end
            T_SEARCH: begin
                if (w_res.done) begin
                    n_rej   = w_res.reject || (w_res.quanta < CBT_QUANTA_MIN);
                    n_brp   = w_res.brp;
                    n_q     = w_res.quanta;
                    n_state = T_FINISH;
                end
            end
            T_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = w_word;
                    n_out_valid = 1'b1;
                    n_state     = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`include "can_bit_timing_calculator_assert.svh"

    `CBT_ASSERT_NOW(a_reject_zero, o_out_valid && o_out_word.status, o_out_word.prescaler == '0 && o_out_word.prop_len == 4'd0 && o_out_word.phase1_len == 4'd0 && o_out_word.phase2_len == 4'd0 && o_out_word.sync_jump_len == 3'd0)
    `CBT_ASSERT_NOW(a_ok_sum, o_out_valid && !o_out_word.status, ({1'b0, o_out_word.prop_len} + {1'b0, o_out_word.phase1_len} + {1'b0, o_out_word.phase2_len}) >= 5'd7 && o_out_word.prescaler != '0 && {1'b0, o_out_word.sync_jump_len} < o_out_word.phase2_len)
    `CBT_ASSERT_NOW(a_done_in_search, w_res.done, r_state == T_SEARCH)
    `CBT_ASSERT_NEXT(a_start_busy, w_start, !o_in_ready)

endmodule
